// ----- rtl/core/ucd_pkg.sv -----
package ucd_pkg;

    localparam int unsigned SEC_PER_DAY     = 86400;
    localparam int unsigned SEC_PER_HOUR    = 3600;
    localparam int unsigned SEC_PER_MIN     = 60;
    localparam int unsigned DAYS_PER_WEEK   = 7;
    localparam int unsigned EPOCH_WEEKDAY   = 4;
    localparam int unsigned EPOCH_SHIFT     = 719468;
    localparam int unsigned DAYS_PER_ERA    = 146097;
    localparam int unsigned DAYS_PER_4Y     = 1460;
    localparam int unsigned DAYS_PER_100Y   = 36524;
    localparam int unsigned ERA_LAST_DAY    = 146096;
    localparam int unsigned DAYS_PER_YEAR   = 365;
    localparam int unsigned ERA_YEARS       = 400;
    localparam int unsigned LAST_SUNDAY_MIN = 25;
    localparam int unsigned JAN_FEB_OFS     = 306;
    localparam int unsigned MAR_YDAY_OFS    = 59;
    localparam int unsigned NONLEAP_CENTURY = 2100;
    localparam int unsigned MP_JAN          = 10;

    // the input range only reaches eras four and five
    localparam int unsigned ERA5_DAY = 5 * DAYS_PER_ERA - EPOCH_SHIFT;
    localparam int unsigned ERA4_OFS = EPOCH_SHIFT - 4 * DAYS_PER_ERA;
    localparam int unsigned YEAR_ERA4 = 4 * ERA_YEARS;
    localparam int unsigned YEAR_ERA5 = 5 * ERA_YEARS;

    localparam logic [3:0] MON_MAR = 4'd2;
    localparam logic [3:0] MON_OCT = 4'd9;

    localparam logic [0:0] REG_DST_ENABLE = 1'b0;

    // exact reciprocal constants, shift = input width + ceil(log2(divisor))
    localparam int unsigned DAY_SHIFT  = 49;
    localparam int unsigned HOUR_SHIFT = 29;
    localparam int unsigned WEEK_SHIFT = 19;
    localparam int unsigned Q4Y_SHIFT  = 29;
    localparam int unsigned MIN_SHIFT  = 18;
    localparam int unsigned YEAR_SHIFT = 27;
    localparam int unsigned MP_SHIFT   = 19;

    localparam logic [32:0] DAY_RECIP = 33'(((64'd1 << DAY_SHIFT)
        + 64'(SEC_PER_DAY) - 64'd1) / 64'(SEC_PER_DAY));
    localparam logic [17:0] HOUR_RECIP = 18'(((64'd1 << HOUR_SHIFT)
        + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR));
    localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_SHIFT)
        + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));
    localparam logic [18:0] Q4Y_RECIP = 19'(((64'd1 << Q4Y_SHIFT)
        + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y));
    localparam logic [12:0] MIN_RECIP = 13'(((64'd1 << MIN_SHIFT)
        + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
    localparam logic [18:0] YEAR_RECIP = 19'(((64'd1 << YEAR_SHIFT)
        + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR));
    localparam logic [11:0] MP_RECIP = 12'(((64'd1 << MP_SHIFT)
        + 64'd153 - 64'd1) / 64'd153);

    typedef struct packed {
        logic [15:0] days;
        logic [16:0] sod;
    } ucd_split_t;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [5:0]  day_of_month;
        logic [3:0]  month;
        logic [11:0] year;
        logic [8:0]  day_of_year;
    } ucd_cal_t;

    // first day of each march-based month within the march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

// ----- rtl/core/ucd_if.sv -----
interface ucd_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] unix_seconds;

    modport source (output valid, output unix_seconds, input ready);
    modport sink (input valid, input unix_seconds, output ready);
endinterface

interface ucd_out_if;
    logic        valid;
    logic        ready;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [2:0]  weekday;
    logic [5:0]  day_of_month;
    logic [3:0]  month;
    logic [11:0] year;
    logic [8:0]  day_of_year;
    logic        dst_active;

    modport source (output valid, output second, output minute, output hour,
                    output weekday, output day_of_month, output month,
                    output year, output day_of_year, output dst_active,
                    input ready);
    modport sink (input valid, input second, input minute, input hour,
                  input weekday, input day_of_month, input month,
                  input year, input day_of_year, input dst_active,
                  output ready);
endinterface

// ----- rtl/core/ucd_day_split.sv -----
module ucd_day_split
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] unix_seconds,
    output logic        out_valid,
    output ucd_split_t  split
);

    logic [64:0] day_prod;
    logic [15:0] days_next;
    logic [16:0] sod_next;

    logic        v1_reg;
    logic [31:0] secs_reg;
    logic [15:0] days_reg;
    logic        v2_reg;
    ucd_split_t  split_reg;

    assign day_prod  = 65'(unix_seconds) * 65'(DAY_RECIP);
    assign days_next = day_prod[DAY_SHIFT +: 16];
    assign sod_next  = 17'(secs_reg - 32'(days_reg) * 32'(SEC_PER_DAY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            secs_reg       <= unix_seconds;
            days_reg       <= days_next;
            split_reg.days <= days_reg;
            split_reg.sod  <= sod_next;
        end
    end

    assign out_valid = v2_reg;
    assign split     = split_reg;

endmodule

// ----- rtl/core/ucd_calc.sv -----
module ucd_calc
    import ucd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       in_valid,
    input  ucd_split_t split,
    output logic       out_valid,
    output ucd_cal_t   cal
);

    logic [6:0] v_reg;

    // weekday, time of day split, day of era
    logic [15:0] wx_next;
    logic [32:0] wq_prod;
    logic [34:0] hour_prod;
    logic        era5_next;
    logic [17:0] doe_next;

    logic [15:0] s3_wx_reg;
    logic [12:0] s3_wq_reg;
    logic [16:0] s3_sod_reg;
    logic [4:0]  s3_hour_reg;
    logic        s3_era5_reg;
    logic [17:0] s3_doe_reg;

    // remainders, four-year count
    logic [2:0]  wday_next;
    logic [11:0] rem2_next;
    logic [36:0] q4y_prod;

    logic [2:0]  s4_wday_reg;
    logic [11:0] s4_rem2_reg;
    logic [4:0]  s4_hour_reg;
    logic        s4_era5_reg;
    logic [17:0] s4_doe_reg;
    logic [6:0]  s4_q4y_reg;

    // year numerator, minute
    logic [2:0]  c100y_next;
    logic [17:0] num_next;
    logic [24:0] min_prod;

    logic [2:0]  s5_wday_reg;
    logic [11:0] s5_rem2_reg;
    logic [4:0]  s5_hour_reg;
    logic        s5_era5_reg;
    logic [17:0] s5_doe_reg;
    logic [17:0] s5_num_reg;
    logic [5:0]  s5_min_reg;

    // year of era, second
    logic [36:0] yoe_prod;
    logic [5:0]  sec_next;

    logic [2:0]  s6_wday_reg;
    logic [4:0]  s6_hour_reg;
    logic [5:0]  s6_min_reg;
    logic [5:0]  s6_sec_reg;
    logic        s6_era5_reg;
    logic [17:0] s6_doe_reg;
    logic [8:0]  s6_yoe_reg;

    // day of march-based year, base year
    logic [1:0]  c100_next;
    logic [8:0]  doy_next;
    logic [11:0] year0_next;

    logic [2:0]  s7_wday_reg;
    logic [4:0]  s7_hour_reg;
    logic [5:0]  s7_min_reg;
    logic [5:0]  s7_sec_reg;
    logic [8:0]  s7_doy_reg;
    logic [11:0] s7_year0_reg;

    // march-based month, leap flag
    logic [10:0] mpx;
    logic [22:0] mp_prod;
    logic        leap_next;

    logic [2:0]  s8_wday_reg;
    logic [4:0]  s8_hour_reg;
    logic [5:0]  s8_min_reg;
    logic [5:0]  s8_sec_reg;
    logic [8:0]  s8_doy_reg;
    logic [11:0] s8_year0_reg;
    logic [3:0]  s8_mp_reg;
    logic        s8_leap_reg;

    // calendar fields
    logic        jan_feb;
    ucd_cal_t    cal_next;
    ucd_cal_t    cal_reg;

    assign wx_next   = split.days + 16'(EPOCH_WEEKDAY);
    assign wq_prod   = 33'(wx_next) * 33'(WEEK_RECIP);
    assign hour_prod = 35'(split.sod) * 35'(HOUR_RECIP);
    assign era5_next = split.days >= 16'(ERA5_DAY);
    assign doe_next  = era5_next ? 18'(split.days) - 18'(ERA5_DAY)
                                 : 18'(split.days) + 18'(ERA4_OFS);

    assign wday_next = 3'(s3_wx_reg - 16'(s3_wq_reg) * 16'(DAYS_PER_WEEK));
    assign rem2_next = 12'(s3_sod_reg - 17'(s3_hour_reg) * 17'(SEC_PER_HOUR));
    assign q4y_prod  = 37'(s3_doe_reg) * 37'(Q4Y_RECIP);

    assign c100y_next = 3'(s4_doe_reg >= 18'(DAYS_PER_100Y))
                      + 3'(s4_doe_reg >= 18'(2 * DAYS_PER_100Y))
                      + 3'(s4_doe_reg >= 18'(3 * DAYS_PER_100Y))
                      + 3'(s4_doe_reg >= 18'(4 * DAYS_PER_100Y));
    assign num_next = s4_doe_reg - 18'(s4_q4y_reg) + 18'(c100y_next)
                    - 18'(s4_doe_reg == 18'(ERA_LAST_DAY));
    assign min_prod = 25'(s4_rem2_reg) * 25'(MIN_RECIP);

    assign yoe_prod = 37'(s5_num_reg) * 37'(YEAR_RECIP);
    assign sec_next = 6'(s5_rem2_reg - 12'(s5_min_reg) * 12'(SEC_PER_MIN));

    assign c100_next = 2'(s6_yoe_reg >= 9'd100) + 2'(s6_yoe_reg >= 9'd200)
                     + 2'(s6_yoe_reg >= 9'd300);
    assign doy_next = 9'(s6_doe_reg - (18'(s6_yoe_reg) * 18'(DAYS_PER_YEAR)
                    + 18'(s6_yoe_reg[8:2]) - 18'(c100_next)));
    assign year0_next = 12'(s6_yoe_reg)
                      + (s6_era5_reg ? 12'(YEAR_ERA5) : 12'(YEAR_ERA4));

    assign mpx     = 11'(s7_doy_reg) * 11'd5 + 11'd2;
    assign mp_prod = 23'(mpx) * 23'(MP_RECIP);
    // the only multiple of four in range that is not a leap year is 2100
    assign leap_next = (s7_year0_reg[1:0] == 2'd0)
                    && (s7_year0_reg != 12'(NONLEAP_CENTURY));

    assign jan_feb = s8_mp_reg >= 4'(MP_JAN);

    always_comb
    begin
        cal_next.second       = s8_sec_reg;
        cal_next.minute       = s8_min_reg;
        cal_next.hour         = s8_hour_reg;
        cal_next.weekday      = s8_wday_reg;
        cal_next.day_of_month = 6'(s8_doy_reg - month_start(s8_mp_reg) + 9'd1);
        if (jan_feb)
        begin
            cal_next.month       = s8_mp_reg - 4'(MP_JAN);
            cal_next.year        = s8_year0_reg + 12'd1;
            cal_next.day_of_year = s8_doy_reg - 9'(JAN_FEB_OFS);
        end
        else
        begin
            cal_next.month       = s8_mp_reg + MON_MAR;
            cal_next.year        = s8_year0_reg;
            cal_next.day_of_year = s8_doy_reg + 9'(MAR_YDAY_OFS)
                                 + 9'(s8_leap_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_wx_reg    <= wx_next;
            s3_wq_reg    <= wq_prod[WEEK_SHIFT +: 13];
            s3_sod_reg   <= split.sod;
            s3_hour_reg  <= hour_prod[HOUR_SHIFT +: 5];
            s3_era5_reg  <= era5_next;
            s3_doe_reg   <= doe_next;

            s4_wday_reg  <= wday_next;
            s4_rem2_reg  <= rem2_next;
            s4_hour_reg  <= s3_hour_reg;
            s4_era5_reg  <= s3_era5_reg;
            s4_doe_reg   <= s3_doe_reg;
            s4_q4y_reg   <= q4y_prod[Q4Y_SHIFT +: 7];

            s5_wday_reg  <= s4_wday_reg;
            s5_rem2_reg  <= s4_rem2_reg;
            s5_hour_reg  <= s4_hour_reg;
            s5_era5_reg  <= s4_era5_reg;
            s5_doe_reg   <= s4_doe_reg;
            s5_num_reg   <= num_next;
            s5_min_reg   <= min_prod[MIN_SHIFT +: 6];

            s6_wday_reg  <= s5_wday_reg;
            s6_hour_reg  <= s5_hour_reg;
            s6_min_reg   <= s5_min_reg;
            s6_sec_reg   <= sec_next;
            s6_era5_reg  <= s5_era5_reg;
            s6_doe_reg   <= s5_doe_reg;
            s6_yoe_reg   <= yoe_prod[YEAR_SHIFT +: 9];

            s7_wday_reg  <= s6_wday_reg;
            s7_hour_reg  <= s6_hour_reg;
            s7_min_reg   <= s6_min_reg;
            s7_sec_reg   <= s6_sec_reg;
            s7_doy_reg   <= doy_next;
            s7_year0_reg <= year0_next;

            s8_wday_reg  <= s7_wday_reg;
            s8_hour_reg  <= s7_hour_reg;
            s8_min_reg   <= s7_min_reg;
            s8_sec_reg   <= s7_sec_reg;
            s8_doy_reg   <= s7_doy_reg;
            s8_year0_reg <= s7_year0_reg;
            s8_mp_reg    <= mp_prod[MP_SHIFT +: 4];
            s8_leap_reg  <= leap_next;

            cal_reg      <= cal_next;
        end
    end

    assign out_valid = v_reg[6];
    assign cal       = cal_reg;

endmodule

// ----- rtl/core/ucd_summer.sv -----
module ucd_summer
    import ucd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     dst_enable,
    input  logic     in_valid,
    input  ucd_cal_t cal,
    output logic     out_valid,
    output ucd_cal_t res,
    output logic     dst_active
);

    logic     summer;
    logic     on_or_after;
    logic     dst_next;
    logic [4:0] hour_sh;
    logic     rollover;
    ucd_cal_t res_next;

    logic     v_reg;
    ucd_cal_t res_reg;
    logic     dst_reg;

    // most recent sunday falls on or after the 25th
    assign on_or_after = 7'(cal.day_of_month)
                      >= 7'(cal.weekday) + 7'(LAST_SUNDAY_MIN);

    always_comb
    begin
        if (cal.month < MON_MAR || cal.month > MON_OCT)
        begin
            summer = 1'b0;
        end
        else if (cal.month == MON_MAR)
        begin
            summer = on_or_after;
        end
        else if (cal.month == MON_OCT)
        begin
            summer = !on_or_after;
        end
        else
        begin
            summer = 1'b1;
        end
    end

    assign dst_next = dst_enable && summer;
    assign hour_sh  = cal.hour + 5'(dst_next);
    assign rollover = hour_sh > 5'd23;

    always_comb
    begin
        res_next = cal;
        if (rollover)
        begin
            res_next.hour         = 5'd0;
            res_next.weekday      = (cal.weekday == 3'(DAYS_PER_WEEK - 1)) ? 3'd0
                                  : cal.weekday + 3'd1;
            res_next.day_of_month = cal.day_of_month + 6'd1;
            res_next.day_of_year  = cal.day_of_year + 9'd1;
        end
        else
        begin
            res_next.hour = hour_sh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
            dst_reg <= dst_next;
        end
    end

    assign out_valid  = v_reg;
    assign res        = res_reg;
    assign dst_active = dst_reg;

endmodule

// ----- rtl/core/unix_time_to_calendar_dst.sv -----
// Converts a 32-bit Unix second count into second, minute, hour, weekday,
// day of month, zero-based month, full year, zero-based day of year and a
// summer time flag, with the European summer hour added when the dst_enable
// register (address 0, reset 1) is set. The pipeline is ten register stages
// deep, and a new word is taken in every cycle while the output side keeps
// up. Divisions by calendar constants are exact reciprocal multiplies, most
// followed by a remainder step in the next stage, and century counts use
// comparisons; the 32-by-33-bit multiply that yields the day count sets the
// stage depth. A stall at the output holds the whole pipeline.
module unix_time_to_calendar_dst
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    ucd_in_if.sink      din,
    ucd_out_if.source   dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       en;
    logic       cfg_wr;
    logic       dst_enable_reg;

    logic       split_valid;
    ucd_split_t split;
    logic       cal_valid;
    ucd_cal_t   cal;
    logic       res_valid;
    ucd_cal_t   res;
    logic       dst_active;

    assign en        = !res_valid || dout.ready;
    assign din.ready = en;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_enable_reg <= 1'b1;
        end
        else if (cfg_wr && paddr[2:2] == REG_DST_ENABLE)
        begin
            dst_enable_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2:2] == REG_DST_ENABLE) ? {31'd0, dst_enable_reg} : 32'd0;

    ucd_day_split u_split (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (din.valid),
        .unix_seconds (din.unix_seconds),
        .out_valid    (split_valid),
        .split        (split)
    );

    ucd_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (split_valid),
        .split     (split),
        .out_valid (cal_valid),
        .cal       (cal)
    );

    ucd_summer u_summer (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .dst_enable (dst_enable_reg),
        .in_valid   (cal_valid),
        .cal        (cal),
        .out_valid  (res_valid),
        .res        (res),
        .dst_active (dst_active)
    );

    assign dout.valid        = res_valid;
    assign dout.second       = res.second;
    assign dout.minute       = res.minute;
    assign dout.hour         = res.hour;
    assign dout.weekday      = res.weekday;
    assign dout.day_of_month = res.day_of_month;
    assign dout.month        = res.month;
    assign dout.year         = res.year;
    assign dout.day_of_year  = res.day_of_year;
    assign dout.dst_active   = dst_active;

endmodule

// ----- rtl/core/ucd_chk.sv -----
module ucd_chk
    import ucd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        din_ready,
    input  logic        dout_valid,
    input  logic        dout_ready,
    input  logic [51:0] dout_word,
    input  logic [3:0]  dout_month,
    input  logic        dout_dst_active
);

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid)
        else $error("result word dropped while stalled");

    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> $stable(dout_word))
        else $error("result word changed while stalled");

    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        din_ready == (!dout_valid || dout_ready))
        else $error("input side not tracking output stall");

    a_dst_window: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && dout_dst_active |-> dout_month >= MON_MAR && dout_month <= MON_OCT)
        else $error("summer time flagged outside march to october");

endmodule

bind unix_time_to_calendar_dst ucd_chk u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .din_ready       (din.ready),
    .dout_valid      (dout.valid),
    .dout_ready      (dout.ready),
    .dout_word       ({dout.second, dout.minute, dout.hour, dout.weekday,
                       dout.day_of_month, dout.month, dout.year,
                       dout.day_of_year, dout.dst_active}),
    .dout_month      (dout.month),
    .dout_dst_active (dout.dst_active)
);
